@@ hw/rtl/rlpe_pkg.sv @@
// Shared types, constants and helper function of the RLP item encoder.
package rlpe_pkg;

	// Request kinds carried in the req_type field.
	typedef enum logic [1:0] {
		REQ_STR_START = 2'd0,
		REQ_STR_DATA  = 2'd1,
		REQ_UINT      = 2'd2,
		REQ_LIST      = 2'd3
	} req_type_t;

	// RLP prefix bases and the short-form length limit.
	localparam logic [7:0] RLP_STR_SHORT  = 8'h80;
	localparam logic [7:0] RLP_STR_LONG   = 8'hb7;
	localparam logic [7:0] RLP_LIST_SHORT = 8'hc0;
	localparam logic [7:0] RLP_LIST_LONG  = 8'hf7;
	localparam logic [7:0] RLP_SINGLE_LIM = 8'h80;
	localparam int unsigned RLP_SHORT_MAX = 55;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		logic [7:0]  head;
		logic [63:0] value;
		logic [3:0]  be_cnt;
		logic [7:0]  tail;
		logic        has_tail;
		logic        err;
	} job_t;

	// Number of bytes in the minimal big-endian form of a value.
	function automatic logic [3:0] byte_count(input logic [63:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (|v[8*i +: 8]) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

@@ hw/rtl/rlpe_req_if.sv @@
// Request channel interface of the RLP item encoder.
interface rlpe_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  data_byte;
	logic [31:0] str_len;
	logic [63:0] uint_value;
	logic [31:0] list_len;

	modport source (
		output valid, req_type, data_byte, str_len, uint_value, list_len,
		input  ready
	);
	modport sink (
		input  valid, req_type, data_byte, str_len, uint_value, list_len,
		output ready
	);
endinterface

@@ hw/rtl/rlpe_rsp_if.sv @@
// Response channel interface of the RLP item encoder.
interface rlpe_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       error;

	modport source (
		output valid, out_byte, last_of_run, error,
		input  ready
	);
	modport sink (
		input  valid, out_byte, last_of_run, error,
		output ready
	);
endinterface

@@ hw/rtl/rlpe_queue.sv @@
// Two-entry job queue between the classifying front and the serialising back.
module rlpe_queue
	import rlpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_job = slot_q[rd_ptr_q];

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Job storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ hw/rtl/rlpe_front.sv @@
// Front end: accepts requests, tracks the open string and classifies each request into a job.
module rlpe_front
	import rlpe_pkg::*;
#(
	parameter int unsigned MAX_LEN_BYTES = 4
) (
	input  logic clk,
	input  logic arst_n,
	rlpe_req_if.sink req,
	input  logic q_full,
	output logic push,
	output job_t push_job
);

	logic [31:0] bytes_rem_q;
	logic [31:0] bytes_rem_d;
	logic [3:0]  str_n;
	logic [3:0]  uint_n;
	logic [3:0]  list_n;
	logic        accept;
	job_t        job;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign push      = accept;
	assign push_job  = job;

	assign str_n  = byte_count({32'd0, req.str_len});
	assign uint_n = byte_count(req.uint_value);
	assign list_n = byte_count({32'd0, req.list_len});

	// Classify the request and work out the string state it leaves behind.
	always_comb begin
		job          = '0;
		bytes_rem_d  = bytes_rem_q;
		unique case (req_type_t'(req.req_type))
			REQ_STR_START: begin
				if (bytes_rem_q != 32'd0) begin
					job.err = 1'b1;
				end else if (req.str_len == 32'd0) begin
					job.head = RLP_STR_SHORT;
				end else if (req.str_len == 32'd1 && req.data_byte < RLP_SINGLE_LIM) begin
					job.head = req.data_byte;
				end else if (req.str_len <= 32'(RLP_SHORT_MAX)) begin
					job.head     = RLP_STR_SHORT + req.str_len[7:0];
					job.tail     = req.data_byte;
					job.has_tail = 1'b1;
					bytes_rem_d  = req.str_len - 32'd1;
				end else if (str_n > 4'(MAX_LEN_BYTES)) begin
					job.err = 1'b1;
				end else begin
					job.head     = RLP_STR_LONG + {4'd0, str_n};
					job.value    = {32'd0, req.str_len};
					job.be_cnt   = str_n;
					job.tail     = req.data_byte;
					job.has_tail = 1'b1;
					bytes_rem_d  = req.str_len - 32'd1;
				end
			end
			REQ_STR_DATA: begin
				if (bytes_rem_q == 32'd0) begin
					job.err = 1'b1;
				end else begin
					job.head    = req.data_byte;
					bytes_rem_d = bytes_rem_q - 32'd1;
				end
			end
			REQ_UINT: begin
				if (req.uint_value == 64'd0) begin
					job.head = RLP_STR_SHORT;
				end else if (req.uint_value < 64'(RLP_SINGLE_LIM)) begin
					job.head = req.uint_value[7:0];
				end else begin
					job.head   = RLP_STR_SHORT + {4'd0, uint_n};
					job.value  = req.uint_value;
					job.be_cnt = uint_n;
				end
			end
			REQ_LIST: begin
				if (req.list_len <= 32'(RLP_SHORT_MAX)) begin
					job.head = RLP_LIST_SHORT + req.list_len[7:0];
				end else if (list_n > 4'(MAX_LEN_BYTES)) begin
					job.err = 1'b1;
				end else begin
					job.head   = RLP_LIST_LONG + {4'd0, list_n};
					job.value  = {32'd0, req.list_len};
					job.be_cnt = list_n;
				end
			end
			default: begin
				job.err = 1'b1;
			end
		endcase
	end

	// String bytes still expected.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_rem_q <= 32'd0;
		end else if (accept) begin
			bytes_rem_q <= bytes_rem_d;
		end
	end

endmodule

@@ hw/rtl/rlpe_back.sv @@
// Back end: serialises queued jobs into output bytes, one per cycle while rsp.ready allows, through an output register.
module rlpe_back
	import rlpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  job_t q_job,
	output logic pop,
	rlpe_rsp_if.source rsp
);

	job_t       cur_q;
	logic       cur_valid_q;
	logic       head_pend_q;
	logic [3:0] cnt_q;
	logic       tail_pend_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_err_q;

	logic       emit;
	logic       emit_last;
	logic [7:0] emit_byte;
	logic [2:0] sel;

	assign rsp.valid       = out_valid_q;
	assign rsp.out_byte    = out_byte_q;
	assign rsp.last_of_run = out_last_q;
	assign rsp.error       = out_err_q;

	assign sel  = 3'(cnt_q - 4'd1);
	assign emit = cur_valid_q && (!out_valid_q || rsp.ready);
	assign pop  = !q_empty && (!cur_valid_q || (emit && emit_last));

	// Pick the next byte of the current job: header, length or value bytes, then tail.
	always_comb begin
		if (head_pend_q) begin
			emit_byte = cur_q.head;
			emit_last = (cnt_q == 4'd0) && !tail_pend_q;
		end else if (cnt_q != 4'd0) begin
			emit_byte = cur_q.value[8*sel +: 8];
			emit_last = (cnt_q == 4'd1) && !tail_pend_q;
		end else begin
			emit_byte = cur_q.tail;
			emit_last = 1'b1;
		end
	end

	// Job sequencing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			head_pend_q <= 1'b0;
			cnt_q       <= 4'd0;
			tail_pend_q <= 1'b0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			head_pend_q <= 1'b1;
			cnt_q       <= q_job.be_cnt;
			tail_pend_q <= q_job.has_tail;
		end else if (emit) begin
			if (emit_last) begin
				cur_valid_q <= 1'b0;
			end else if (head_pend_q) begin
				head_pend_q <= 1'b0;
			end else if (cnt_q != 4'd0) begin
				cnt_q <= cnt_q - 4'd1;
			end else begin
				tail_pend_q <= 1'b0;
			end
		end
	end

	// Current job payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_job;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
			out_err_q  <= cur_q.err;
		end
	end

endmodule

@@ hw/rtl/rlp_item_encoder_unit.sv @@
// A request's first byte passes through the queue slot, current-job and output registers.
// One output byte per cycle while rsp.ready allows; a request producing k bytes holds
// the serialiser until all k are emitted, so string data bytes stream at one per cycle.
// A two-entry job queue lets requests be accepted while earlier jobs are serialised.
// Reset clears the open-string count, the queue and the output register; no clearing pass.
module rlp_item_encoder_unit
	import rlpe_pkg::*;
#(
	parameter int unsigned MAX_LEN_BYTES = 4
) (
	input  logic clk,
	input  logic arst_n,
	rlpe_req_if.sink   req,
	rlpe_rsp_if.source rsp
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	job_t push_job;
	job_t pop_job;

	// Request classification and string tracking.
	rlpe_front #(
		.MAX_LEN_BYTES(MAX_LEN_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_full   (q_full),
		.push     (q_push),
		.push_job (push_job)
	);

	// Decoupling queue.
	rlpe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// Byte serialiser.
	rlpe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (pop_job),
		.pop     (q_pop),
		.rsp     (rsp)
	);

endmodule
